### hdl/kset_pkg.sv
`default_nettype none

package kset_pkg;

  localparam int KEY_W         = 32;
  localparam int KIND_W        = 3;
  localparam int TALLY_W       = 5;
  localparam int BANK_W        = 2;
  localparam int MAX_RESULTS   = 32;
  localparam int RES_W         = $clog2(MAX_RESULTS + 1);
  localparam int DEF_SET_DEPTH = 16;

  localparam logic [TALLY_W-1:0] TALLY_MAX = 5'd31;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ADD_A     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_B     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_U     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INTERSECT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SYMDIFF   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COUNT     = 3'd5;

  // Banks of the shared key memory.
  localparam logic [BANK_W-1:0] BANK_A = 2'd0;
  localparam logic [BANK_W-1:0] BANK_B = 2'd1;
  localparam logic [BANK_W-1:0] BANK_U = 2'd2;

endpackage

`default_nettype wire

### hdl/kset_store.sv
`default_nettype none

module kset_store #(
  parameter  int SET_DEPTH = kset_pkg::DEF_SET_DEPTH,
  localparam int IW        = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [kset_pkg::BANK_W+IW-1:0]         waddr,
  input  wire logic [kset_pkg::KEY_W-1:0]             wdata,
  input  wire logic                                   re,
  input  wire logic [kset_pkg::BANK_W+IW-1:0]         raddr,
  output logic      [kset_pkg::KEY_W-1:0]             rdata
);

  localparam int MEM_DEPTH = 3 * (2 ** IW);

  // Three banks of 2**IW entries each, addressed as {bank, index}.
  logic [kset_pkg::KEY_W-1:0] mem [0:MEM_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/key_set_intersection_engine_unit.sv
// Key set intersection engine.
// The input channel (in_valid, in_stall, in_kind, in_key) takes one item at a
// time: an insert into set A, set B or the universe set, or a query. Every
// item except the unused kinds six and seven gives results on the output
// channel (out_valid, out_stall, out_*), the last of them with out_is_last.
// An insert writes the key at acceptance and then, in S_INS, presents its
// status item on the output once the output register is free. Queries stream
// members from one key memory with one read port: each source entry is read
// (S_SRC, S_SRCD) and then compared with the entries of the other store in
// turn (S_OTH, S_OTHD), ahead of a decision in S_DEC. A compare stops at the
// first hit. Reset empties all three stores by clearing their fill
// counts; the key memory itself is not cleared. While the receiver stalls,
// one result waits in the output register and the query pauses once it has
// a further result to hand over; in_stall is high whenever an item is in
// progress, so the next item enters once the previous one has handed its
// last result to the output register.
`default_nettype none

module key_set_intersection_engine_unit #(
  parameter int SET_DEPTH = kset_pkg::DEF_SET_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [kset_pkg::KIND_W-1:0] in_kind,
  input  wire logic signed [kset_pkg::KEY_W-1:0]  in_key,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [kset_pkg::KEY_W-1:0]  out_member,
  output logic             [kset_pkg::TALLY_W-1:0] out_tally,
  output logic                                    out_empty_answer,
  output logic                                    out_status,
  output logic                                    out_is_last
);

  localparam int IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int FW = $clog2(SET_DEPTH + 1);
  localparam int AW = kset_pkg::BANK_W + IW;
  localparam logic [FW-1:0] FULL = FW'(SET_DEPTH);
  localparam logic [kset_pkg::RES_W-1:0] RES_MAX = kset_pkg::RES_W'(kset_pkg::MAX_RESULTS);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_SRC, S_SRCD, S_OTH, S_OTHD, S_DEC, S_FIN
  } state_t;

  state_t                          state_r;
  logic [kset_pkg::KIND_W-1:0]     kind_r;
  logic [FW-1:0]                   fill_a_r, fill_b_r, fill_u_r;
  logic [FW-1:0]                   src_idx_r, oth_idx_r;
  logic                            phase_r, sec_r, found_r;
  logic [kset_pkg::KEY_W-1:0]      cur_key_r, pend_key_r;
  logic                            pend_v_r;
  logic [kset_pkg::RES_W-1:0]      n_r;
  logic [kset_pkg::TALLY_W-1:0]    tally_r;
  logic                            status_r;
  logic                            out_valid_r;
  logic [kset_pkg::KEY_W-1:0]      out_member_r;
  logic [kset_pkg::TALLY_W-1:0]    out_tally_r;
  logic                            out_empty_r, out_status_r, out_last_r;

  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [kset_pkg::KEY_W-1:0]      mem_rdata;

  logic [kset_pkg::BANK_W-1:0]     src_bank, oth_bank, ins_bank;
  logic [FW-1:0]                   src_fill, oth_fill, ins_fill;
  logic                            ins_kind, want_in, out_free, out_load;

  assign out_free = !out_valid_r || !out_stall;
  assign want_in  = (kind_r == kset_pkg::KIND_INTERSECT);

  // A result item enters the output register in this cycle.
  assign out_load = out_free &&
                    ((state_r == S_INS) || (state_r == S_FIN) ||
                     (state_r == S_DEC && kind_r != kset_pkg::KIND_COUNT &&
                      found_r == want_in && pend_v_r));

  // Source and compared store for the current pass of a query.
  always_comb begin
    src_bank = kset_pkg::BANK_A;
    oth_bank = kset_pkg::BANK_B;
    src_fill = fill_a_r;
    oth_fill = fill_b_r;
    if (kind_r == kset_pkg::KIND_SYMDIFF && !phase_r) begin
      src_bank = kset_pkg::BANK_B;
      oth_bank = kset_pkg::BANK_A;
      src_fill = fill_b_r;
      oth_fill = fill_a_r;
    end else if (kind_r == kset_pkg::KIND_COUNT) begin
      src_bank = kset_pkg::BANK_U;
      src_fill = fill_u_r;
      oth_bank = sec_r ? kset_pkg::BANK_B : kset_pkg::BANK_A;
      oth_fill = sec_r ? fill_b_r : fill_a_r;
    end
  end

  always_comb begin
    ins_kind = 1'b1;
    ins_bank = kset_pkg::BANK_A;
    ins_fill = fill_a_r;
    case (in_kind)
      kset_pkg::KIND_ADD_A: begin
        ins_bank = kset_pkg::BANK_A;
        ins_fill = fill_a_r;
      end
      kset_pkg::KIND_ADD_B: begin
        ins_bank = kset_pkg::BANK_B;
        ins_fill = fill_b_r;
      end
      kset_pkg::KIND_ADD_U: begin
        ins_bank = kset_pkg::BANK_U;
        ins_fill = fill_u_r;
      end
      default: ins_kind = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = (state_r == S_IDLE) && in_valid && ins_kind && (ins_fill < FULL);
    mem_waddr = {ins_bank, ins_fill[IW-1:0]};
    mem_re    = 1'b0;
    mem_raddr = {src_bank, src_idx_r[IW-1:0]};
    case (state_r)
      S_SRC: begin
        mem_re    = 1'b1;
        mem_raddr = {src_bank, src_idx_r[IW-1:0]};
      end
      S_OTH: begin
        mem_re    = 1'b1;
        mem_raddr = {oth_bank, oth_idx_r[IW-1:0]};
      end
      default: mem_re = 1'b0;
    endcase
  end

  kset_store #(
    .SET_DEPTH (SET_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_key),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_a_r    <= '0;
      fill_b_r    <= '0;
      fill_u_r    <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r    <= in_kind;
            src_idx_r <= '0;
            phase_r   <= 1'b0;
            sec_r     <= 1'b0;
            pend_v_r  <= 1'b0;
            n_r       <= '0;
            tally_r   <= '0;
            if (ins_kind) begin
              status_r <= (ins_fill >= FULL);
              if (ins_fill < FULL) begin
                case (in_kind)
                  kset_pkg::KIND_ADD_A: fill_a_r <= fill_a_r + 1'b1;
                  kset_pkg::KIND_ADD_B: fill_b_r <= fill_b_r + 1'b1;
                  default:              fill_u_r <= fill_u_r + 1'b1;
                endcase
              end
              state_r <= S_INS;
            end else if (in_kind == kset_pkg::KIND_INTERSECT ||
                         in_kind == kset_pkg::KIND_SYMDIFF ||
                         in_kind == kset_pkg::KIND_COUNT) begin
              state_r <= S_SRC;
            end
          end
        end
        S_INS: begin
          if (out_free) begin
            out_member_r <= '0;
            out_tally_r  <= '0;
            out_empty_r  <= 1'b0;
            out_status_r <= status_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_SRC: begin
          if (src_idx_r >= src_fill || n_r == RES_MAX) begin
            // The symmetric difference runs a second pass with the sets swapped.
            if (kind_r == kset_pkg::KIND_SYMDIFF && !phase_r) begin
              phase_r   <= 1'b1;
              src_idx_r <= '0;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_SRCD;
          end
        end
        S_SRCD: begin
          cur_key_r <= mem_rdata;
          oth_idx_r <= '0;
          found_r   <= 1'b0;
          sec_r     <= 1'b0;
          state_r   <= S_OTH;
        end
        S_OTH: begin
          if (oth_idx_r >= oth_fill) begin
            // A count checks set A first and then set B.
            if (kind_r == kset_pkg::KIND_COUNT && !sec_r) begin
              sec_r     <= 1'b1;
              oth_idx_r <= '0;
            end else begin
              state_r <= S_DEC;
            end
          end else begin
            state_r <= S_OTHD;
          end
        end
        S_OTHD: begin
          if (mem_rdata == cur_key_r) begin
            found_r <= 1'b1;
            state_r <= S_DEC;
          end else begin
            oth_idx_r <= oth_idx_r + 1'b1;
            state_r   <= S_OTH;
          end
        end
        S_DEC: begin
          if (kind_r == kset_pkg::KIND_COUNT) begin
            if (!found_r && tally_r != kset_pkg::TALLY_MAX) begin
              tally_r <= tally_r + 1'b1;
            end
            src_idx_r <= src_idx_r + 1'b1;
            state_r   <= S_SRC;
          end else if (found_r == want_in) begin
            // The newest hit is held back until we know whether it is the last.
            if (!pend_v_r) begin
              pend_v_r   <= 1'b1;
              pend_key_r <= cur_key_r;
              n_r        <= n_r + 1'b1;
              src_idx_r  <= src_idx_r + 1'b1;
              state_r    <= S_SRC;
            end else if (out_free) begin
              out_member_r <= pend_key_r;
              out_tally_r  <= '0;
              out_empty_r  <= 1'b0;
              out_status_r <= 1'b0;
              out_last_r   <= 1'b0;
              pend_key_r   <= cur_key_r;
              n_r          <= n_r + 1'b1;
              src_idx_r    <= src_idx_r + 1'b1;
              state_r      <= S_SRC;
            end
          end else begin
            src_idx_r <= src_idx_r + 1'b1;
            state_r   <= S_SRC;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_member_r <= (kind_r != kset_pkg::KIND_COUNT && pend_v_r) ? pend_key_r : '0;
            out_tally_r  <= (kind_r == kset_pkg::KIND_COUNT) ? tally_r : '0;
            out_empty_r  <= (kind_r != kset_pkg::KIND_COUNT) && !pend_v_r;
            out_status_r <= 1'b0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_member       = out_member_r;
  assign out_tally        = out_tally_r;
  assign out_empty_answer = out_empty_r;
  assign out_status       = out_status_r;
  assign out_is_last      = out_last_r;

endmodule

`default_nettype wire
